>>> rtl/rdps_pkg.sv
// ----------------------------------------------------------------------------
// rdps_pkg: shared types and constants of the RC DAC pulse-width servo
// Holds the register map, the queue entry format and the bit-length helper.
// ----------------------------------------------------------------------------
package rdps_pkg;

   // Register map of the CSR write channel
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 32;
   localparam logic [CsrIndexW-1:0] CSR_DEADBAND         = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_RAIL_MARGIN      = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_MAX_CHARGE_US    = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_MAX_DISCHARGE_US = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_TAU_CHARGE_NS    = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_TAU_DISCHARGE_NS = 3'd5;
   localparam logic [CsrIndexW-1:0] CSR_RATIO_FLOOR      = 3'd6;

   // Pulse kind decided by the front end
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_CHARGE    = 2'd1;
   localparam logic [1:0] KIND_DISCHARGE = 2'd2;

   // Full-scale level of the Q0.16 rail
   localparam logic [15:0] RAIL = 16'hFFFF;

   // Quotient bits of the ratio divider
   localparam int DivSteps = 16;

   // ln(2) in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Reciprocal of 1000 scaled by 2^36, exact floor for dividends below 2^26
   localparam logic [26:0] RECIP_1000 = 27'd68719477;

   typedef struct packed {
      logic [15:0] deadband;
      logic [15:0] rail_margin;
      logic [15:0] max_charge_us;
      logic [15:0] max_discharge_us;
      logic [29:0] tau_charge_ns;
      logic [29:0] tau_discharge_ns;
      logic [15:0] ratio_floor;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        sample_level;
      logic signed [16:0] level_error;
      logic [1:0]         kind;
      logic [15:0]        num;
      logic [15:0]        den;
   } entry_type;

   // Number of significant bits of a 16-bit value
   function automatic logic [4:0] bit_length(input logic [15:0] r);
      logic [4:0] b;
      b = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (r[i]) begin
            b = 5'(i + 1);
         end
      end
      return b;
   endfunction

endpackage

>>> rtl/rdps_if.sv
// ----------------------------------------------------------------------------
// rdps_if: valid/ready channels of the RC DAC pulse-width servo
// Request, response and CSR write channels, each with source and sink views.
// ----------------------------------------------------------------------------
interface rdps_req_if #(parameter int ADC_BITS = 10);
   logic                valid;
   logic                ready;
   logic [15:0]         target_level;
   logic [ADC_BITS-1:0] adc_sample;
   modport source (output valid, target_level, adc_sample, input ready);
   modport sink (input valid, target_level, adc_sample, output ready);
endinterface

interface rdps_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        sample_level;
   logic signed [16:0] level_error;
   logic [15:0]        pulse_length_us;
   logic               charge_flag;
   logic               discharge_flag;
   modport source (output valid, sample_level, level_error, pulse_length_us,
                   charge_flag, discharge_flag, input ready);
   modport sink (input valid, sample_level, level_error, pulse_length_us,
                 charge_flag, discharge_flag, output ready);
endinterface

interface rdps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rdps_pkg::CsrIndexW-1:0]   index;
   logic [rdps_pkg::CsrDataW-1:0]    wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/rc_dac_pulse_width_servo_core.sv
// ----------------------------------------------------------------------------
// rc_dac_pulse_width_servo_core: RC DAC pulse-width servo
// Turns a target level and an ADC reading of the RC node into a pulse length.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries target_level (Q0.16) and a raw adc_sample; rsp_if returns
//   sample_level, level_error, pulse_length_us and the charge/discharge flags,
//   one response per request, in order. csr_if writes the seven registers
//   (index 0..6) and is always ready; write only while the block is idle.
// Flow:
//   The front end takes one request per cycle, while req_if.ready is high, into
//   a two-entry queue. The back end handles one item at a time and takes no new
//   item before its response is loaded: an item without a pulse goes straight to
//   the output state; an item that saturates at the ratio floor leaves after the
//   16-step ratio divider; a full computation also runs one squaring per log
//   fraction bit in the 31x31 multiplier, then the ln, tau and cap steps.
// Reset:
//   Synchronous reset empties the pipeline and loads the register defaults.
// Stalls:
//   A response waits in its output register while rsp_if.ready is low; the
//   back end stops, the queue fills, and then req_if.ready drops.
// ----------------------------------------------------------------------------
module rc_dac_pulse_width_servo_core #(
   parameter int ADC_BITS      = 10,
   parameter int LOG_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   rdps_req_if.sink    req_if,
   rdps_rsp_if.source  rsp_if,
   rdps_csr_if.sink    csr_if
);

   rdps_pkg::cfg_type   cfg_ff, cfg_in;
   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   rdps_pkg::entry_type push_entry, pop_entry;

   assign csr_if.ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            rdps_pkg::CSR_DEADBAND:         cfg_in.deadband         = csr_if.wdata[15:0];
            rdps_pkg::CSR_RAIL_MARGIN:      cfg_in.rail_margin      = csr_if.wdata[15:0];
            rdps_pkg::CSR_MAX_CHARGE_US:    cfg_in.max_charge_us    = csr_if.wdata[15:0];
            rdps_pkg::CSR_MAX_DISCHARGE_US: cfg_in.max_discharge_us = csr_if.wdata[15:0];
            rdps_pkg::CSR_TAU_CHARGE_NS:    cfg_in.tau_charge_ns    = csr_if.wdata[29:0];
            rdps_pkg::CSR_TAU_DISCHARGE_NS: cfg_in.tau_discharge_ns = csr_if.wdata[29:0];
            rdps_pkg::CSR_RATIO_FLOOR:      cfg_in.ratio_floor      = csr_if.wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband         <= 16'd131;
         cfg_ff.rail_margin      <= 16'd66;
         cfg_ff.max_charge_us    <= 16'd10000;
         cfg_ff.max_discharge_us <= 16'd10000;
         cfg_ff.tau_charge_ns    <= 30'd1000000;
         cfg_ff.tau_discharge_ns <= 30'd1000000;
         cfg_ff.ratio_floor      <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rdps_front #(.ADC_BITS(ADC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rdps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rdps_back #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule

>>> rtl/rdps_front.sv
// ----------------------------------------------------------------------------
// rdps_front: sample conversion and pulse classification
// Scales the ADC code to Q0.16, forms the error, and picks the pulse kind
// together with the numerator and denominator of the log ratio.
// ----------------------------------------------------------------------------
module rdps_front #(
   parameter int ADC_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   rdps_req_if.sink            req_if,
   input  rdps_pkg::cfg_type   cfg,
   output logic                push_valid,
   input  logic                push_ready,
   output rdps_pkg::entry_type push_entry
);

   localparam int XW = ADC_BITS + 16;
   localparam int RW = 34 - ADC_BITS;
   localparam logic [63:0] RecipFull = (64'd1 << 32) / ((64'd1 << ADC_BITS) - 64'd1);
   localparam logic [RW-1:0] Recip = RecipFull[RW-1:0];
   localparam logic [XW-1:0] FullX = XW'((64'd1 << ADC_BITS) - 64'd1);

   logic              s1_valid_ff, s1_valid_in;
   logic [15:0]       tgt_ff, tgt_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [15:0]       est_ff, est_in;
   logic [XW+RW-1:0]  prod;

   logic [XW-1:0]      qf, rem;
   logic [15:0]        smp;
   logic signed [16:0] err;
   logic [16:0]        mag;
   logic               act;
   logic [15:0]        top, tc, sc, cnum, cden, td, sd;
   logic               cvalid, dvalid;
   logic [1:0]         kind;

   assign req_if.ready = !s1_valid_ff || push_ready;

   // Scale raw code by 65535 and estimate the quotient by reciprocal
   always_comb begin
      x_in   = {req_if.adc_sample, 16'd0} - XW'(req_if.adc_sample);
      prod   = (XW+RW)'(x_in) * (XW+RW)'(Recip);
      est_in = prod[47:32];
      tgt_in = req_if.target_level;
      if (req_if.valid && req_if.ready) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         tgt_ff <= tgt_in;
         x_ff   <= x_in;
         est_ff <= est_in;
      end
   end

   // Correct the estimate, form the error and classify
   always_comb begin
      qf   = {est_ff, {ADC_BITS{1'b0}}} - XW'(est_ff);
      rem  = x_ff - qf;
      smp  = (rem >= FullX) ? est_ff + 16'd1 : est_ff;
      err  = $signed({1'b0, tgt_ff}) - $signed({1'b0, smp});
      mag  = err[16] ? 17'(-err) : 17'(err);
      act  = mag >= {1'b0, cfg.deadband};

      // charge: clamp below the upper rail
      top    = rdps_pkg::RAIL - cfg.rail_margin;
      tc     = (tgt_ff > top) ? top : tgt_ff;
      sc     = (smp > top) ? top : smp;
      cden   = rdps_pkg::RAIL - sc;
      cnum   = rdps_pkg::RAIL - tc;
      cvalid = (cden > cfg.rail_margin) && (cnum != cden);

      // discharge: clamp above the lower rail
      td     = (tgt_ff < cfg.rail_margin) ? cfg.rail_margin : tgt_ff;
      sd     = (smp < cfg.rail_margin) ? cfg.rail_margin : smp;
      dvalid = (tgt_ff < smp) && (sd != 16'd0) && (td != sd);

      if (!act) begin
         kind = rdps_pkg::KIND_NONE;
      end else if (!err[16] && (err != 17'sd0)) begin
         kind = cvalid ? rdps_pkg::KIND_CHARGE : rdps_pkg::KIND_NONE;
      end else begin
         kind = dvalid ? rdps_pkg::KIND_DISCHARGE : rdps_pkg::KIND_NONE;
      end

      push_entry.sample_level = smp;
      push_entry.level_error  = err;
      push_entry.kind         = kind;
      push_entry.num          = (kind == rdps_pkg::KIND_CHARGE) ? cnum : td;
      push_entry.den          = (kind == rdps_pkg::KIND_CHARGE) ? cden : sd;
   end

   assign push_valid = s1_valid_ff;

endmodule

>>> rtl/rdps_queue.sv
// ----------------------------------------------------------------------------
// rdps_queue: two-entry queue between front and back end
// Decouples classification from the multi-cycle pulse computation.
// ----------------------------------------------------------------------------
module rdps_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rdps_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rdps_pkg::entry_type pop_entry
);

   rdps_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // Advance pointers and count on each transfer
   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop_valid && pop_ready;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/rdps_back.sv
// ----------------------------------------------------------------------------
// rdps_back: pulse length sequencer
// Divides for the ratio, runs the squaring log, scales by tau and caps the
// pulse, then holds the result in the response register.
// ----------------------------------------------------------------------------
module rdps_back #(
   parameter int LOG_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rdps_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  rdps_pkg::entry_type pop_entry,
   rdps_rsp_if.source          rsp_if
);

   localparam int L     = LOG_FRAC_BITS;
   localparam int NlogW = L + 5;
   localparam int ProdW = 30 + NlogW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_CHK   = 4'd2;
   localparam logic [3:0] ST_LOG   = 4'd3;
   localparam logic [3:0] ST_LN    = 4'd4;
   localparam logic [3:0] ST_TAU   = 4'd5;
   localparam logic [3:0] ST_SCALE = 4'd6;
   localparam logic [3:0] ST_CAP   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        smp_ff, smp_in;
   logic signed [16:0] err_ff, err_in;
   logic [15:0]        den_ff, den_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic [30:0]        z_ff, z_in;
   logic [L-1:0]       lfrac_ff, lfrac_in;
   logic [4:0]         shift_ff, shift_in;
   logic [NlogW-1:0]   nln_ff, nln_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic               big_ff, big_in;
   logic [16:0]        qm_ff, qm_in;
   logic [15:0]        pulse_ff, pulse_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        o_smp_ff, o_pulse_ff;
   logic signed [16:0] o_err_ff;
   logic               o_chg_ff, o_dis_ff;
   logic               load_out;

   logic               is_chg;
   logic [15:0]        max_raw, max_eff;
   logic [29:0]        tau;
   logic [16:0]        rem2;
   logic               ge;
   logic [4:0]         b;
   logic [61:0]        sq;
   logic [31:0]        z2;
   logic [NlogW-1:0]   nlog2;
   logic [NlogW+31:0]  lnprod;
   logic [ProdW:0]     ysum;
   logic [35:0]        y;
   logic [52:0]        qprod;

   // Select per-direction registers
   always_comb begin
      is_chg  = kind_ff == rdps_pkg::KIND_CHARGE;
      max_raw = is_chg ? cfg.max_charge_us : cfg.max_discharge_us;
      max_eff = (max_raw == 16'd0) ? 16'd1 : max_raw;
      tau     = is_chg ? cfg.tau_charge_ns : cfg.tau_discharge_ns;
   end

   assign pop_ready = state_ff == ST_IDLE;
   assign load_out  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   // Sequence one item through divide, log, scale and cap, or straight to output
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      smp_in   = smp_ff;
      err_in   = err_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      z_in     = z_ff;
      lfrac_in = lfrac_ff;
      shift_in = shift_ff;
      nln_in   = nln_ff;
      prod_in  = prod_ff;
      big_in   = big_ff;
      qm_in    = qm_ff;
      pulse_in = pulse_ff;

      rem2   = {rem_ff, 1'b0};
      ge     = rem2 >= {1'b0, den_ff};
      b      = rdps_pkg::bit_length(quo_ff);
      sq     = 62'(z_ff) * 62'(z_ff);
      z2     = sq[61:30];
      nlog2  = {shift_ff, {L{1'b0}}} - NlogW'(lfrac_ff);
      lnprod = (NlogW+32)'(nlog2) * (NlogW+32)'(rdps_pkg::LN2_Q32)
               + (NlogW+32)'(64'h8000_0000);
      ysum   = (ProdW+1)'(prod_ff) + (ProdW+1)'(64'd500 << L);
      y      = 36'(ysum >> L);
      qprod  = 53'(y[25:0]) * 53'(rdps_pkg::RECIP_1000);

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               kind_in = pop_entry.kind;
               smp_in  = pop_entry.sample_level;
               err_in  = pop_entry.level_error;
               den_in  = pop_entry.den;
               rem_in  = pop_entry.num;
               quo_in  = 16'd0;
               cnt_in  = 5'd0;
               if (pop_entry.kind == rdps_pkg::KIND_NONE) begin
                  pulse_in = 16'd0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = ge ? 16'(rem2 - {1'b0, den_ff}) : rem2[15:0];
            quo_in = {quo_ff[14:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(rdps_pkg::DivSteps - 1)) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (quo_ff <= cfg.ratio_floor) begin
               pulse_in = max_eff;
               state_in = ST_OUT;
            end else begin
               z_in     = 31'({15'd0, quo_ff} << (5'd31 - b));
               shift_in = 5'd17 - b;
               lfrac_in = '0;
               cnt_in   = 5'd0;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            z_in     = z2[31] ? z2[31:1] : z2[30:0];
            lfrac_in = (lfrac_ff << 1) | L'(z2[31]);
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == 5'(L - 1)) begin
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            nln_in   = lnprod[NlogW+31:32];
            state_in = ST_TAU;
         end
         ST_TAU: begin
            prod_in  = ProdW'(tau) * ProdW'(nln_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            big_in   = |y[35:26];
            qm_in    = qprod[52:36];
            state_in = ST_CAP;
         end
         ST_CAP: begin
            pulse_in = (big_ff || (qm_ff > {1'b0, max_eff})) ? max_eff : qm_ff[15:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until the receiver takes it
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      smp_ff   <= smp_in;
      err_ff   <= err_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      z_ff     <= z_in;
      lfrac_ff <= lfrac_in;
      shift_ff <= shift_in;
      nln_ff   <= nln_in;
      prod_ff  <= prod_in;
      big_ff   <= big_in;
      qm_ff    <= qm_in;
      pulse_ff <= pulse_in;
      if (load_out) begin
         o_smp_ff   <= smp_ff;
         o_err_ff   <= err_ff;
         o_pulse_ff <= pulse_ff;
         o_chg_ff   <= (kind_ff == rdps_pkg::KIND_CHARGE) && (pulse_ff != 16'd0);
         o_dis_ff   <= (kind_ff == rdps_pkg::KIND_DISCHARGE) && (pulse_ff != 16'd0);
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.sample_level    = o_smp_ff;
   assign rsp_if.level_error     = o_err_ff;
   assign rsp_if.pulse_length_us = o_pulse_ff;
   assign rsp_if.charge_flag     = o_chg_ff;
   assign rsp_if.discharge_flag  = o_dis_ff;

   // Both flags never raised together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(o_chg_ff && o_dis_ff))
      else $error("charge and discharge flags both set");

   // A flag is raised exactly when the pulse is nonzero
   a_flag_matches_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((o_chg_ff || o_dis_ff) == (o_pulse_ff != 16'd0)))
      else $error("pulse flag disagrees with pulse length");

   // Divider leaves only toward the ratio check
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_DIV || state_ff == ST_CHK))
      else $error("divider left to an unexpected state");

   // Nothing is popped while an item is in flight
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> (state_ff == ST_IDLE))
      else $error("queue popped outside idle");

endmodule

>>> test/tb_channels.sv
// ----------------------------------------------------------------------------
// tb_channels: clock-edge counting helpers for the servo testbench
// Holds the cycle counter interface used by tb_top to bound the run.
// ----------------------------------------------------------------------------
interface tb_cycle_if (input logic clock);
   int unsigned count = 0;
   always @(posedge clock) begin
      count <= count + 1;
   end
endinterface

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RC DAC pulse-width servo core
// Drives level/sample requests with random gaps, predicts each response in
// fixed point, and compares every response field against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int AdcBits  = 10;
   localparam int LogBits  = 16;
   localparam int CycleCap = 2000000;

   typedef struct {
      logic [15:0] target_level;
      logic [9:0]  adc_sample;
   } level_req_type;

   typedef struct {
      logic [15:0]        sample_level;
      logic signed [16:0] level_error;
      logic [15:0]        pulse_length_us;
      logic               charge_flag;
      logic               discharge_flag;
   } pulse_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rdps_req_if #(.ADC_BITS(AdcBits)) req_if ();
   rdps_rsp_if rsp_if ();
   rdps_csr_if csr_if ();
   tb_cycle_if cyc (.clock(clock));

   rc_dac_pulse_width_servo_core #(.ADC_BITS(AdcBits), .LOG_FRAC_BITS(LogBits)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   // Clock: 10 time units per period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Servo settings mirrored by the predictor
   logic [15:0] deadband_q, margin_q, max_chg_q, max_dis_q, floor_q;
   logic [29:0] tau_chg_q, tau_dis_q;

   level_req_type pending_reqs[$];
   pulse_rsp_type expected_pulses[$];
   int unsigned mismatch_count = 0;
   bit stim_done = 1'b0;
   bit req_done = 1'b0;

   // -ln(r/65536) in Q4.16 by repeated squaring
   function automatic logic [63:0] neg_ln(input logic [31:0] r);
      logic [63:0] z, frac, nl2;
      int b;
      b = 0;
      for (int i = 0; i < 32; i++) if (r[i]) b = i + 1;
      if (b == 0) return 64'd16 << LogBits;
      z = 64'(r) << (31 - b);
      frac = 0;
      for (int i = 0; i < LogBits; i++) begin
         z = (z * z) >> 30;
         frac = frac << 1;
         if (z >= (64'd2 << 30)) begin
            frac = frac | 64'd1;
            z = z >> 1;
         end
      end
      nl2 = (64'(17 - b) << LogBits) - frac;
      return (nl2 * 64'(rdps_pkg::LN2_Q32) + (64'd1 << 31)) >> 32;
   endfunction

   function automatic logic [15:0] pulse_for_ratio(input logic [31:0] ratio,
         input logic [29:0] tau, input logic [15:0] max_us);
      logic [63:0] t;
      logic [31:0] cap;
      cap = (max_us == 0) ? 32'd1 : 32'(max_us);
      if (ratio <= 32'(floor_q)) return cap[15:0];
      if (ratio >= 32'd65536) return 16'd0;
      t = (64'(tau) * neg_ln(ratio) + (64'd500 << LogBits)) / (64'd1000 << LogBits);
      if (t > 64'(cap)) t = 64'(cap);
      return t[15:0];
   endfunction

   function automatic pulse_rsp_type predict_pulse(input level_req_type it);
      pulse_rsp_type p;
      logic [31:0] tgt, smp, top, den, num, mag;
      int err;
      tgt = 32'(it.target_level);
      smp = (32'(it.adc_sample) * 32'd65535) / 32'd1023;
      err = int'(tgt) - int'(smp);
      mag = (err < 0) ? 32'(-err) : 32'(err);
      p.sample_level = smp[15:0];
      p.level_error = 17'(err);
      p.pulse_length_us = 16'd0;
      if (mag >= 32'(deadband_q)) begin
         if (err > 0) begin
            top = 32'd65535 - 32'(margin_q);
            if (tgt > top) tgt = top;
            if (smp > top) smp = top;
            den = 32'd65535 - smp;
            num = 32'd65535 - tgt;
            if (den > 32'(margin_q))
               p.pulse_length_us = pulse_for_ratio(32'((64'(num) << 16) / den),
                                                   tau_chg_q, max_chg_q);
         end else if (err < 0) begin
            if (tgt < 32'(margin_q)) tgt = 32'(margin_q);
            if (smp < 32'(margin_q)) smp = 32'(margin_q);
            if (smp != 0)
               p.pulse_length_us = pulse_for_ratio(32'((64'(tgt) << 16) / smp),
                                                   tau_dis_q, max_dis_q);
         end
      end
      p.charge_flag = (err > 0) && (p.pulse_length_us != 0);
      p.discharge_flag = (err <= 0) && (p.pulse_length_us != 0);
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0d: mismatch %s", cyc.count, what);
      mismatch_count++;
   endtask

   // Driver: feed pending items with random gaps, update at falling edge
   int req_gap = 0;
   initial begin
      req_if.valid = 1'b0;
      req_if.target_level = '0;
      req_if.adc_sample = '0;
   end
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_done) begin
         // hold the item until the transfer
      end else if (req_gap > 0) begin
         req_if.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         level_req_type it;
         it = pending_reqs.pop_front();
         req_if.valid <= 1'b1;
         req_if.target_level <= it.target_level;
         req_if.adc_sample <= it.adc_sample;
         req_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Monitor: predict on request transfer, check on response transfer
   int rsp_gap = 0;
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      req_done <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         level_req_type it;
         it.target_level = req_if.target_level;
         it.adc_sample = req_if.adc_sample;
         expected_pulses.push_back(predict_pulse(it));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pulses.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            pulse_rsp_type e;
            e = expected_pulses.pop_front();
            if (rsp_if.sample_level !== e.sample_level)
               report_mismatch($sformatf("sample_level %0d want %0d",
                  rsp_if.sample_level, e.sample_level));
            if (rsp_if.level_error !== e.level_error)
               report_mismatch($sformatf("level_error %0d want %0d",
                  rsp_if.level_error, e.level_error));
            if (rsp_if.pulse_length_us !== e.pulse_length_us)
               report_mismatch($sformatf("pulse_length_us %0d want %0d",
                  rsp_if.pulse_length_us, e.pulse_length_us));
            if (rsp_if.charge_flag !== e.charge_flag)
               report_mismatch("charge_flag");
            if (rsp_if.discharge_flag !== e.discharge_flag)
               report_mismatch("discharge_flag");
         end
      end
   end

   // Receiver stalls, changed at falling edge
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_if.valid && rsp_if.ready && $urandom_range(0, 3) == 0)
            rsp_gap <= int'($urandom_range(0, 14));
      end
   end

   task automatic write_reg(input logic [rdps_pkg::CsrIndexW-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         rdps_pkg::CSR_DEADBAND:         deadband_q = val[15:0];
         rdps_pkg::CSR_RAIL_MARGIN:      margin_q = val[15:0];
         rdps_pkg::CSR_MAX_CHARGE_US:    max_chg_q = val[15:0];
         rdps_pkg::CSR_MAX_DISCHARGE_US: max_dis_q = val[15:0];
         rdps_pkg::CSR_TAU_CHARGE_NS:    tau_chg_q = val[29:0];
         rdps_pkg::CSR_TAU_DISCHARGE_NS: tau_dis_q = val[29:0];
         rdps_pkg::CSR_RATIO_FLOOR:      floor_q = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Wait until all queued items are sent and answered, then settle
   task automatic drain();
      while (pending_reqs.size() > 0 || req_if.valid || expected_pulses.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic push_req(input logic [15:0] tgt, input logic [9:0] raw);
      level_req_type it;
      it.target_level = tgt;
      it.adc_sample = raw;
      pending_reqs.push_back(it);
   endtask

   task automatic random_items(input int n);
      for (int i = 0; i < n; i++) begin
         logic [9:0] raw;
         logic [15:0] tgt;
         raw = 10'($urandom_range(0, 1023));
         case ($urandom_range(0, 3))
            0: tgt = 16'($urandom);
            1: tgt = 16'((32'(raw) * 65535) / 1023 + $urandom_range(0, 400) - 200);
            2: tgt = $urandom_range(0, 1) ? 16'($urandom_range(0, 300))
                                          : 16'($urandom_range(65235, 65535));
            default: tgt = 16'((32'(raw) * 65535) / 1023 + $urandom_range(0, 8000) - 4000);
         endcase
         push_req(tgt, raw);
      end
   endtask

   // Stimulus: directed corners, then random phases across settings
   initial begin
      deadband_q = 16'd131; margin_q = 16'd66; max_chg_q = 16'd10000;
      max_dis_q = 16'd10000; tau_chg_q = 30'd1000000; tau_dis_q = 30'd1000000;
      floor_q = 16'd1;
      csr_if.valid = 1'b0; csr_if.index = '0; csr_if.wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: rails, deadband edges, equal levels, floor saturation
      push_req(16'd0, 10'd0);
      push_req(16'hFFFF, 10'd1023);
      push_req(16'hFFFF, 10'd0);
      push_req(16'd0, 10'd1023);
      push_req(16'd131, 10'd0);
      push_req(16'd130, 10'd0);
      push_req(16'd32767, 10'd511);
      push_req(16'd65500, 10'd1020);
      push_req(16'd10, 10'd1);
      push_req(16'd40000, 10'd600);
      push_req(16'd20000, 10'd700);
      push_req(16'h5555, 10'h2AA);
      push_req(16'hAAAA, 10'h155);
      drain();

      // Extremes of every register
      write_reg(rdps_pkg::CSR_DEADBAND, 32'd0);
      write_reg(rdps_pkg::CSR_RAIL_MARGIN, 32'd1);
      write_reg(rdps_pkg::CSR_MAX_CHARGE_US, 32'd65535);
      write_reg(rdps_pkg::CSR_MAX_DISCHARGE_US, 32'd1);
      write_reg(rdps_pkg::CSR_TAU_CHARGE_NS, 32'd1000000000);
      write_reg(rdps_pkg::CSR_TAU_DISCHARGE_NS, 32'd1);
      write_reg(rdps_pkg::CSR_RATIO_FLOOR, 32'd0);
      push_req(16'd0, 10'd0);
      push_req(16'hFFFF, 10'd0);
      push_req(16'd0, 10'd1023);
      push_req(16'hFFFF, 10'd1022);
      random_items(150);
      drain();

      write_reg(rdps_pkg::CSR_DEADBAND, 32'd65535);
      write_reg(rdps_pkg::CSR_RAIL_MARGIN, 32'd65535);
      write_reg(rdps_pkg::CSR_MAX_CHARGE_US, 32'd1);
      write_reg(rdps_pkg::CSR_MAX_DISCHARGE_US, 32'd65535);
      write_reg(rdps_pkg::CSR_TAU_CHARGE_NS, 32'd1);
      write_reg(rdps_pkg::CSR_TAU_DISCHARGE_NS, 32'd1000000000);
      write_reg(rdps_pkg::CSR_RATIO_FLOOR, 32'd65535);
      push_req(16'hFFFF, 10'd0);
      push_req(16'd0, 10'd1023);
      random_items(50);
      drain();

      // Random settings for the rest
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(rdps_pkg::CSR_DEADBAND, $urandom_range(0, 600));
         write_reg(rdps_pkg::CSR_RAIL_MARGIN, $urandom_range(1, 2000));
         write_reg(rdps_pkg::CSR_MAX_CHARGE_US, $urandom_range(1, 65535));
         write_reg(rdps_pkg::CSR_MAX_DISCHARGE_US, $urandom_range(1, 65535));
         write_reg(rdps_pkg::CSR_TAU_CHARGE_NS, $urandom_range(1, 1000000000));
         write_reg(rdps_pkg::CSR_TAU_DISCHARGE_NS, $urandom_range(1, 1000000000));
         write_reg(rdps_pkg::CSR_RATIO_FLOOR, $urandom_range(0, 3000));
         random_items(100);
         drain();
      end
      write_reg(rdps_pkg::CSR_DEADBAND, $urandom);
      write_reg(rdps_pkg::CSR_RATIO_FLOOR, $urandom);
      write_reg(rdps_pkg::CSR_TAU_CHARGE_NS, {2'b00, 30'h3FFF_FFFF});
      random_items(380);
      stim_done = 1'b1;
   end

   // End of run and watchdog
   initial begin
      wait (stim_done);
      drain();
      if (mismatch_count == 0 && expected_pulses.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (cyc.count > CycleCap) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule

>>> files.f
rtl/rdps_pkg.sv
rtl/rdps_if.sv
rtl/rdps_front.sv
rtl/rdps_queue.sv
rtl/rdps_back.sv
rtl/rc_dac_pulse_width_servo_core.sv
test/tb_channels.sv
test/tb_top.sv
